>>> hdl/sensor_risk_classifier_top_macros.svh
// Assertion macros shared by the sensor risk classifier RTL.
`ifndef SENSOR_RISK_CLASSIFIER_TOP_MACROS_SVH
`define SENSOR_RISK_CLASSIFIER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SRC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/src_pkg.sv
// Types, constants and helper functions for the sensor risk classifier.
`default_nettype none

package src_pkg;

    // Port widths
    localparam int S_TDATA_W = 40;  // adc 12 + temp 11 + humidity 10, padded to bytes
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 24;  // 22 result bits, padded to bytes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 11;

    // Moisture conversion
    localparam int ADC_FULL   = 4095;
    localparam int MOIST_FULL = 1000;
    localparam int ROUND_BIAS = 2047;

    // Fixed flood thresholds, tenths
    localparam logic [9:0] FLOOD_HIGH_MOIST = 10'd850;
    localparam logic [9:0] FLOOD_HIGH_HUM   = 10'd800;
    localparam logic [9:0] FLOOD_MID_MOIST  = 10'd750;
    localparam logic [9:0] FLOOD_MID_HUM    = 10'd750;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STRESS_HIGH_BELOW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRESS_MID_BELOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEAT_HIGH_TEMP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEAT_DRY_HUMIDITY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HEAT_MID_TEMP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DROUGHT_HIGH_DROP = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DROUGHT_MID_DROP  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DROUGHT_MID_BELOW = 3'd7;

    typedef struct packed {
        logic [9:0]         stress_high_below;
        logic [9:0]         stress_mid_below;
        logic signed [10:0] heat_high_temp;
        logic [9:0]         heat_dry_humidity;
        logic signed [10:0] heat_mid_temp;
        logic [9:0]         drought_high_drop;
        logic [9:0]         drought_mid_drop;
        logic [9:0]         drought_mid_below;
    } src_cfg_t;

    localparam src_cfg_t CFG_RESET = '{
        stress_high_below: 10'd200,
        stress_mid_below:  10'd400,
        heat_high_temp:    11'sd380,
        heat_dry_humidity: 10'd400,
        heat_mid_temp:     11'sd320,
        drought_high_drop: 10'd150,
        drought_mid_drop:  10'd80,
        drought_mid_below: 10'd500
    };

    typedef enum logic [1:0] {
        LVL_LOW  = 2'd0,
        LVL_MED  = 2'd1,
        LVL_HIGH = 2'd2
    } src_level_t;

    typedef enum logic [2:0] {
        STAT_NORMAL   = 3'd0,
        STAT_HEAT     = 3'd1,
        STAT_MODERATE = 3'd2,
        STAT_STRESS   = 3'd3,
        STAT_SEVERE   = 3'd4,
        STAT_FLOOD    = 3'd5,
        STAT_SENSOR   = 3'd6
    } src_status_t;

    typedef struct packed {
        logic        alert;
        src_status_t status;
        src_level_t  flood;
        src_level_t  drought;
        src_level_t  heat;
        src_level_t  need;
        logic [9:0]  moist;
    } src_result_t;

    // Window memory and accumulator controls
    typedef struct packed {
        logic wr;
        logic clr;
        logic rd;
    } src_win_ctl_t;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MUL   = 7'b0000010,
        ST_DIV   = 7'b0000100,
        ST_WRITE = 7'b0001000,
        ST_SUM   = 7'b0010000,
        ST_GRADE = 7'b0100000,
        ST_OUT   = 7'b1000000
    } src_state_t;

    // prod = adc*1000 + 2047; returns 1000 - prod/4095, floored at 0.
    // prod = q0*4096 + lo = q0*4095 + (q0 + lo), and q0 + lo < 2*4095,
    // so one conditional increment finishes the quotient.
    function automatic logic [9:0] src_moist(input logic [22:0] prod);
        logic [10:0] q0;
        logic [12:0] r;
        logic [10:0] q;
        q0 = prod[22:12];
        r  = {1'b0, prod[11:0]} + {2'b00, q0};
        q  = q0 + ((r >= 13'(ADC_FULL)) ? 11'd1 : 11'd0);
        return (q >= 11'(MOIST_FULL)) ? 10'd0 : 10'(11'(MOIST_FULL) - q);
    endfunction

endpackage

`default_nettype wire

>>> hdl/sensor_risk_classifier_top.sv
// Top level of the sensor risk classifier: sequencer, registers and output stage.
//
// Usage:
//   Input stream s_*: one word per sensor sample. s_tdata carries soil_adc,
//   air_temp_x10 and air_humidity_x10; s_tuser carries climate_valid.
//   Output stream m_*: one word per sample with moisture, four risk grades,
//   node status and the alert bit.
//   Config port: cfg_we/cfg_index/cfg_data writes one threshold register per
//   cycle; write only while the block is idle.
// Sequence:
//   Valid sample: multiply, divide, ring write, window sum and grade steps;
//   the window sum reads the ring one entry per cycle into one shared adder.
//   Invalid sample: multiply, divide and grade steps, no ring update.
//   s_tready is high only between samples, so a new sample is accepted
//   only after the previous one has passed the grade step.
// Reset (aresetn low, synchronous): thresholds return to defaults, ring slot
//   and fill count clear, output goes empty. Ring contents are not cleared;
//   drought grading waits until the ring has been filled.
// Back-pressure: the result sits in an output register; a new sample is
//   accepted while it waits. A second result holds in the grade step until
//   m_tready frees the register.
`default_nettype none
`include "sensor_risk_classifier_top_macros.svh"

module sensor_risk_classifier_top #(
    parameter int WINDOW_DEPTH = 10
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input stream
    input  wire logic                            s_tvalid,
    output      logic                            s_tready,
    // [11:0] soil_adc, [22:12] air_temp_x10, [32:23] air_humidity_x10, [39:33] zero
    input  wire logic [src_pkg::S_TDATA_W-1:0]   s_tdata,
    // [0] climate_valid
    input  wire logic [src_pkg::S_TUSER_W-1:0]   s_tuser,
    // result stream
    output      logic                            m_tvalid,
    input  wire logic                            m_tready,
    // [9:0] soil_moisture_x10, [11:10] water_need_level, [13:12] heat_level,
    // [15:14] drought_level, [17:16] flood_level, [20:18] node_status,
    // [21] alert_led, [23:22] zero
    output      logic [src_pkg::M_TDATA_W-1:0]   m_tdata,
    // config write port
    input  wire logic                            cfg_we,
    input  wire logic [src_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [src_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import src_pkg::*;

    localparam int AW    = $clog2(WINDOW_DEPTH);
    localparam int CW    = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = 10 + AW;
    localparam int THR_W = 11 + AW;

    // thresholds
    src_cfg_t cfg_reg;

    // sequencer
    src_state_t    state_reg, state_next;
    logic [AW-1:0] slot_reg, slot_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic          load;
    src_win_ctl_t  win_ctl;

    // sample datapath
    logic [11:0]        adc_reg;
    logic signed [10:0] temp_reg;
    logic [9:0]         hum_reg;
    logic               valid_reg;
    logic [22:0]        prod_reg;
    logic [9:0]         moist_reg;
    logic [THR_W-1:0]   thr_hi_reg;
    logic [THR_W-1:0]   thr_mid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic [SUM_W-1:0] win_sum;
    logic             full;
    src_result_t      res;

    // ---------------- config registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_STRESS_HIGH_BELOW: cfg_reg.stress_high_below <= cfg_data[9:0];
                REG_STRESS_MID_BELOW:  cfg_reg.stress_mid_below  <= cfg_data[9:0];
                REG_HEAT_HIGH_TEMP:    cfg_reg.heat_high_temp    <= cfg_data;
                REG_HEAT_DRY_HUMIDITY: cfg_reg.heat_dry_humidity <= cfg_data[9:0];
                REG_HEAT_MID_TEMP:     cfg_reg.heat_mid_temp     <= cfg_data;
                REG_DROUGHT_HIGH_DROP: cfg_reg.drought_high_drop <= cfg_data[9:0];
                REG_DROUGHT_MID_DROP:  cfg_reg.drought_mid_drop  <= cfg_data[9:0];
                REG_DROUGHT_MID_BELOW: cfg_reg.drought_mid_below <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // ---------------- sequencer ----------------
    assign s_tready = (state_reg == ST_IDLE);
    assign full     = (fill_reg == CW'(WINDOW_DEPTH));

    always_comb begin
        state_next    = state_reg;
        slot_next     = slot_reg;
        fill_next     = fill_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        load          = 1'b0;
        win_ctl       = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                state_next = valid_reg ? ST_WRITE : ST_GRADE;
            end
            ST_WRITE: begin
                // store sample, advance ring, restart the sum
                win_ctl.wr = 1'b1;
                win_ctl.clr = 1'b1;
                slot_next = (slot_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
                fill_next = full ? fill_reg : fill_reg + 1'b1;
                cnt_next  = '0;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                // one entry per cycle; the last add lands on the exit edge
                if (cnt_reg == CW'(WINDOW_DEPTH)) begin
                    state_next = ST_GRADE;
                end else begin
                    win_ctl.rd = 1'b1;
                    cnt_next   = cnt_reg + 1'b1;
                end
            end
            ST_GRADE: begin
                if (!m_tvalid_reg || m_tready) begin
                    load          = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            slot_reg     <= '0;
            fill_reg     <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            slot_reg     <= slot_next;
            fill_reg     <= fill_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            adc_reg   <= s_tdata[11:0];
            temp_reg  <= s_tdata[22:12];
            hum_reg   <= s_tdata[32:23];
            valid_reg <= s_tuser[0];
        end
        if (state_reg == ST_MUL) begin
            prod_reg <= 23'(adc_reg) * 23'(MOIST_FULL) + 23'(ROUND_BIAS);
        end
        if (state_reg == ST_DIV) begin
            moist_reg <= src_moist(prod_reg);
        end
        if (state_reg == ST_WRITE) begin
            thr_hi_reg  <= THR_W'(WINDOW_DEPTH)
                           * THR_W'({1'b0, moist_reg} + {1'b0, cfg_reg.drought_high_drop});
            thr_mid_reg <= THR_W'(WINDOW_DEPTH)
                           * THR_W'({1'b0, moist_reg} + {1'b0, cfg_reg.drought_mid_drop});
        end
        if (load) begin
            m_tdata_reg <= {2'b00, res.alert, res.status, res.flood, res.drought,
                            res.heat, res.need, res.moist};
        end
    end

    src_window #(
        .DEPTH (WINDOW_DEPTH),
        .AW    (AW),
        .SUM_W (SUM_W)
    ) u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (win_ctl),
        .wr_addr (slot_reg),
        .wr_data (moist_reg),
        .rd_addr (cnt_reg[AW-1:0]),
        .sum     (win_sum)
    );

    src_grade #(
        .SUM_W (SUM_W),
        .THR_W (THR_W)
    ) u_grade (
        .cfg     (cfg_reg),
        .moist   (moist_reg),
        .temp    (temp_reg),
        .hum     (hum_reg),
        .valid   (valid_reg),
        .full    (full),
        .sum     (win_sum),
        .thr_hi  (thr_hi_reg),
        .thr_mid (thr_mid_reg),
        .res     (res)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------- assertions ----------------
    `SRC_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accepted word while busy")
    `SRC_ASSERT_NOW(a_ring_prefix, fill_reg != CW'(WINDOW_DEPTH), CW'(slot_reg) == fill_reg, "ring slot out of step with fill count")
    `SRC_ASSERT_NOW(a_fill_bound, 1'b1, fill_reg <= CW'(WINDOW_DEPTH), "fill count past window depth")
    `SRC_ASSERT_NEXT(a_result_loaded, state_reg == ST_GRADE && (!m_tvalid_reg || m_tready), m_tvalid_reg && s_tready, "graded word not presented")

endmodule

`default_nettype wire

>>> hdl/src_window.sv
// Moisture ring memory with the shared accumulate adder.
`default_nettype none

module src_window #(
    parameter int DEPTH = 10,
    parameter int AW    = 4,
    parameter int SUM_W = 14
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire src_pkg::src_win_ctl_t ctl,
    input  wire logic [AW-1:0]         wr_addr,
    input  wire logic [9:0]            wr_data,
    input  wire logic [AW-1:0]         rd_addr,
    output      logic [SUM_W-1:0]      sum
);
    import src_pkg::*;

    logic [9:0]       mem [DEPTH];
    logic [9:0]       rd_data_reg;
    logic             pend_reg;
    logic [SUM_W-1:0] acc_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr) begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // read data is registered; add it in the cycle after the read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
        end else begin
            pend_reg <= ctl.rd;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.clr) begin
            acc_reg <= '0;
        end else if (pend_reg) begin
            acc_reg <= acc_reg + SUM_W'(rd_data_reg);
        end
    end

    assign sum = acc_reg;

endmodule

`default_nettype wire

>>> hdl/src_grade.sv
// Risk grading and status priority for one sample.
`default_nettype none

module src_grade #(
    parameter int SUM_W = 14,
    parameter int THR_W = 15
) (
    input  wire src_pkg::src_cfg_t    cfg,
    input  wire logic [9:0]           moist,
    input  wire logic signed [10:0]   temp,
    input  wire logic [9:0]           hum,
    input  wire logic                 valid,
    input  wire logic                 full,
    input  wire logic [SUM_W-1:0]     sum,
    input  wire logic [THR_W-1:0]     thr_hi,
    input  wire logic [THR_W-1:0]     thr_mid,
    output      src_pkg::src_result_t res
);
    import src_pkg::*;

    logic signed [10:0] hi_temp;
    logic signed [10:0] mid_temp;
    logic [THR_W-1:0]   sum_ext;
    src_level_t         need;
    src_level_t         heat;
    src_level_t         flood;
    src_level_t         drought;
    src_status_t        status;

    assign hi_temp  = cfg.heat_high_temp;
    assign mid_temp = cfg.heat_mid_temp;
    assign sum_ext  = THR_W'(sum);

    always_comb begin
        need = LVL_LOW;
        if (moist < cfg.stress_high_below) begin
            need = LVL_HIGH;
        end else if (moist < cfg.stress_mid_below) begin
            need = LVL_MED;
        end

        heat = LVL_LOW;
        if (temp >= hi_temp && hum <= cfg.heat_dry_humidity) begin
            heat = LVL_HIGH;
        end else if (temp >= mid_temp) begin
            heat = LVL_MED;
        end

        flood = LVL_LOW;
        if (moist >= FLOOD_HIGH_MOIST && hum >= FLOOD_HIGH_HUM) begin
            flood = LVL_HIGH;
        end else if (moist >= FLOOD_MID_MOIST && hum >= FLOOD_MID_HUM) begin
            flood = LVL_MED;
        end

        // sum - D*moist >= D*drop  <=>  sum >= D*(moist + drop)
        drought = LVL_LOW;
        if (full) begin
            if (moist < cfg.stress_mid_below && sum_ext >= thr_hi) begin
                drought = LVL_HIGH;
            end else if (moist < cfg.drought_mid_below && sum_ext >= thr_mid) begin
                drought = LVL_MED;
            end
        end

        if (flood == LVL_HIGH) begin
            status = STAT_FLOOD;
        end else if (heat == LVL_HIGH && need == LVL_HIGH) begin
            status = STAT_SEVERE;
        end else if (need == LVL_HIGH) begin
            status = STAT_STRESS;
        end else if (need == LVL_MED) begin
            status = STAT_MODERATE;
        end else if (heat == LVL_HIGH) begin
            status = STAT_HEAT;
        end else begin
            status = STAT_NORMAL;
        end

        res.moist = moist;
        if (valid) begin
            res.need    = need;
            res.heat    = heat;
            res.drought = drought;
            res.flood   = flood;
            res.status  = status;
            res.alert   = (status == STAT_STRESS) || (status == STAT_SEVERE)
                          || (status == STAT_FLOOD);
        end else begin
            res.need    = LVL_LOW;
            res.heat    = LVL_LOW;
            res.drought = LVL_LOW;
            res.flood   = LVL_LOW;
            res.status  = STAT_SENSOR;
            res.alert   = 1'b1;
        end
    end

endmodule

`default_nettype wire
